### design/sitoa_pkg.sv
// shared constants and types for the signed integer to decimal text converter
`default_nettype none
package sitoa_pkg;

    // default width of the input integer
    localparam int VALUE_BITS_DEF = 32;

    // width of the running character count on the result side
    localparam int CHAR_INDEX_BITS = 4;

    // ascii codes
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // double-dabble correction: digits of five and up get three added before the shift
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;

    // per-cycle command to the row of digit cells
    typedef struct packed {
        logic clear;      // zero every digit
        logic bit_step;   // take one binary bit in at the bottom, double-dabble
        logic digit_step; // move every digit one cell towards the top
    } cell_ctrl_t;

endpackage : sitoa_pkg
`default_nettype wire

### design/signed_int_to_decimal_ascii_top.sv
// top level: signed integer in, decimal ascii characters out, one per request
// Sequence: the value is taken in idle, shifted bit-serially into the cell chain, leading zero
// digits are dropped, then a minus sign if negative and the digits follow, one character per
// cycle while m_axis_tready is high; a new value is taken only after the last character is loaded.
// The bit-serial pass through the cell chain sets the pace per value; output stalls slow it further.
// Reset: aresetn, synchronous active low, returns the sequencer to idle and drops m_axis_tvalid.
`default_nettype none
module signed_int_to_decimal_ascii_top
    import sitoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // value, zero filled to whole bytes
    input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // char_code [7:0], char_index [11:8], zeros above
    output logic [15:0]                              m_axis_tdata,
    output logic                                     m_axis_tlast,   // last_char
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready
);

    // decimal digits needed for a magnitude up to 2**VALUE_BITS - 1
    localparam int NDIGITS  = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DL_BITS  = $clog2(NDIGITS + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SKIP  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_DIGIT = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [VALUE_BITS-1:0]        mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic [CNT_BITS-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [DL_BITS-1:0]           left_reg, left_next;
    logic [CHAR_INDEX_BITS-1:0]   index_reg, index_next;
    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   m_code_reg, m_code_next;
    logic [CHAR_INDEX_BITS-1:0]   m_index_reg, m_index_next;
    logic                         m_last_reg, m_last_next;

    logic [VALUE_BITS-1:0]        in_value;
    logic                         in_neg;
    logic [VALUE_BITS-1:0]        in_mag;
    logic                         out_free;
    logic                         out_load;
    cell_ctrl_t                   ctrl;
    logic [3:0]                   top_digit;
    logic [CHAR_INDEX_BITS-1:0]   index_inc;

    logic [3:0] digit_chain [NDIGITS+1];
    logic       carry_chain [NDIGITS+1];

    // input value and its magnitude; the most negative value maps to 2**(VALUE_BITS-1)
    assign in_value = s_axis_tdata[VALUE_BITS-1:0];
    assign in_neg   = in_value[VALUE_BITS-1];
    assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;

    assign s_axis_tready = state_reg[0];
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign top_digit     = digit_chain[NDIGITS];
    assign index_inc     = index_reg + 1'b1;

    // row of digit cells, least significant at the bottom
    assign digit_chain[0] = '0;
    assign carry_chain[0] = mag_reg[VALUE_BITS-1];

    for (genvar i = 0; i < NDIGITS; i++) begin : g_cell
        sitoa_bcd_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .carry_in  (carry_chain[i]),
            .digit_in  (digit_chain[i]),
            .carry_out (carry_chain[i+1]),
            .digit_out (digit_chain[i+1])
        );
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        left_next    = left_reg;
        index_next   = index_reg;
        m_code_next  = m_code_reg;
        m_index_next = m_index_reg;
        m_last_next  = m_last_reg;
        out_load     = 1'b0;
        ctrl         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    mag_next     = in_mag;
                    neg_next     = in_neg;
                    bit_cnt_next = '0;
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                ctrl.bit_step = 1'b1;
                mag_next      = mag_reg << 1;
                bit_cnt_next  = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CNT_BITS'(VALUE_BITS - 1)) begin
                    left_next  = DL_BITS'(NDIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, always keeping the units digit
                index_next = '0;
                if (top_digit == 4'd0 && left_reg > DL_BITS'(1)) begin
                    ctrl.digit_step = 1'b1;
                    left_next       = left_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_code_next  = ASCII_MINUS;
                    m_index_next = index_inc;
                    m_last_next  = 1'b0;
                    index_next   = index_inc;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    ctrl.digit_step = 1'b1;
                    m_code_next     = ASCII_ZERO + {4'd0, top_digit};
                    m_index_next    = index_inc;
                    m_last_next     = (left_reg == DL_BITS'(1));
                    index_next      = index_inc;
                    left_next       = left_reg - 1'b1;
                    if (left_reg == DL_BITS'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        left_reg    <= left_next;
        index_reg   <= index_next;
        m_code_reg  <= m_code_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, m_index_reg, m_code_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule : signed_int_to_decimal_ascii_top
`default_nettype wire

### design/sitoa_bcd_cell.sv
// one decimal digit cell of the binary-to-bcd shift chain
`default_nettype none
module sitoa_bcd_cell
    import sitoa_pkg::*;
(
    input  wire logic       aclk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       carry_in,   // bit from the next lower cell
    input  wire logic [3:0] digit_in,   // digit from the next lower cell
    output logic            carry_out,  // bit handed to the next higher cell
    output logic [3:0]      digit_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add-three correction ahead of the doubling
    always_comb begin
        adj = (digit_reg >= BCD_ADJ_LIMIT) ? digit_reg + BCD_ADJ : digit_reg;
    end

    assign carry_out = adj[3];
    assign digit_out = digit_reg;

    // next digit value
    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.bit_step) begin
            digit_next = {adj[2:0], carry_in};
        end else if (ctrl.digit_step) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule : sitoa_bcd_cell
`default_nettype wire
